/* design/pcf_pkg.sv */
package pcf_pkg;

  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;
  localparam int TIME_W = 32;
  localparam int POLL_W = 5;
  localparam int PROF_W = 2;
  localparam int CFG_W  = 16;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int HEARTBEAT_SECONDS_DEF = 30;
  localparam int POLL_FIELD_MAX        = 31;
  localparam int MS_PER_SECOND         = 1000;

  localparam logic [1:0] REG_PROFILE  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_DISTANCE = 2'd2;

  localparam logic [CFG_W-1:0] INTERVAL_BY_PROFILE [4] = '{16'd10, 16'd5, 16'd2, 16'd0};
  localparam logic [CFG_W-1:0] DISTANCE_BY_PROFILE [4] = '{16'd5, 16'd25, 16'd50, 16'd0};

  localparam int COS_DEPTH = 256;
  localparam int COS_SPAN  = (COS_DEPTH > 1) ? COS_DEPTH - 1 : 1;
  localparam int IDX_W     = $clog2(COS_DEPTH);
  localparam int COS_W     = 17;

  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int NUM_W  = DLAT_W + IDX_W + 1;

  localparam longint unsigned MDEG_90  = 64'd90000000;
  localparam longint unsigned MDEG_180 = 64'd180000000;

  localparam int NEAR_BITS = 20;
  localparam int PX_BITS   = 36;
  localparam int XS_W      = PX_BITS - 8 + 1;
  localparam int YS_W      = NEAR_BITS + 8;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = XS_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] DIST_SCALE = MUL_B_W'(5288561);

  // The mean-latitude index divides by 180e6 as a shift by 8 followed by a multiply with
  // the rounded-up reciprocal of 703125, which is exact for shifted dividends below 2^28.
  localparam int              IDX_PRE_SHIFT   = 8;
  localparam int              IDX_RECIP_SHIFT = 48;
  localparam longint unsigned IDX_DIVISOR     = MDEG_180 >> IDX_PRE_SHIFT;
  localparam logic [MUL_B_W-1:0] IDX_RECIP =
    MUL_B_W'(((64'd1 << IDX_RECIP_SHIFT) + IDX_DIVISOR - 64'd1) / IDX_DIVISOR);

  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE    = 64'd1 << 30;
  localparam longint unsigned TAYLOR_DIV [10] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  typedef logic [COS_W-1:0] cos_lut_t [COS_DEPTH];

  function automatic cos_lut_t build_cos_lut();
    cos_lut_t          lut;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    for (int i = 0; i < COS_DEPTH; i++) begin
      x    = (PIHALF_Q30 * longint'(i)) / COS_SPAN;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = Q30_ONE;
      sum  = longint'(Q30_ONE);
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(Q30_ONE)) begin
        sum = longint'(Q30_ONE);
      end
      lut[i] = COS_W'((longint'(sum) + 8192) >> 14);
    end
    return lut;
  endfunction

  localparam cos_lut_t COS_LUT = build_cos_lut();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIST,
    ST_DONE
  } pcf_state_e;

  typedef enum logic [3:0] {
    DS_IDLE,
    DS_ABS,
    DS_DECIDE,
    DS_IDX,
    DS_MUL_PX,
    DS_CHK_PX,
    DS_MUL_XX,
    DS_MUL_YY,
    DS_MUL_TT,
    DS_MUL_TS,
    DS_CMP
  } dist_state_e;

  typedef struct packed {
    logic done;
    logic far;
  } dist_stat_t;

endpackage

/* design/pcf_dist.sv */
module pcf_dist
  import pcf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [LAT_W-1:0] lat_i,
  input  logic signed [LON_W-1:0] lon_i,
  input  logic signed [LAT_W-1:0] last_lat_i,
  input  logic signed [LON_W-1:0] last_lon_i,
  input  logic [CFG_W-1:0]        thr_i,
  output dist_stat_t              stat_o
);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(COS_DEPTH - 1);

  dist_state_e               state_q, state_d;
  logic signed [DLAT_W-1:0]  dlat_q, dlat_d;
  logic signed [DLON_W-1:0]  dlon_q, dlon_d;
  logic signed [DLAT_W-1:0]  msum_q, msum_d;
  logic [DLAT_W-1:0]         ad_q, ad_d;
  logic [DLON_W-1:0]         ao_q, ao_d;
  logic [DLAT_W-1:0]         ms_q, ms_d;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [XS_W-1:0]           xs_q, xs_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic [PROD_W-1:0]         acc_q, acc_d;
  logic                      done_q, done_d;
  logic                      far_q, far_d;

  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [NUM_W-1:0]          num;
  logic [PX_BITS:0]          px_rnd;
  logic [YS_W-1:0]           ys;

  always_comb begin
    state_d = state_q;
    dlat_d  = dlat_q;
    dlon_d  = dlon_q;
    msum_d  = msum_q;
    ad_d    = ad_q;
    ao_d    = ao_q;
    ms_d    = ms_q;
    idx_d   = idx_q;
    xs_d    = xs_q;
    acc_d   = acc_q;
    done_d  = 1'b0;
    far_d   = far_q;
    mul_a   = '0;
    mul_b   = '0;
    num     = NUM_W'(ms_q) * NUM_W'(COS_SPAN) + NUM_W'(MDEG_90);
    px_rnd  = {1'b0, prod_q[PX_BITS-1:0]} + (PX_BITS+1)'(128);
    ys      = {ad_q[NEAR_BITS-1:0], 8'b0};

    case (state_q)
      DS_IDLE: begin
        if (start_i) begin
          dlat_d  = DLAT_W'(lat_i) - DLAT_W'(last_lat_i);
          dlon_d  = DLON_W'(lon_i) - DLON_W'(last_lon_i);
          msum_d  = DLAT_W'(lat_i) + DLAT_W'(last_lat_i);
          state_d = DS_ABS;
        end
      end
      DS_ABS: begin
        ad_d    = dlat_q[DLAT_W-1] ? DLAT_W'(-dlat_q) : DLAT_W'(dlat_q);
        ao_d    = dlon_q[DLON_W-1] ? DLON_W'(-dlon_q) : DLON_W'(dlon_q);
        ms_d    = msum_q[DLAT_W-1] ? DLAT_W'(-msum_q) : DLAT_W'(msum_q);
        state_d = DS_DECIDE;
      end
      DS_DECIDE: begin
        if (ad_q[DLAT_W-1:NEAR_BITS] != '0) begin
          done_d  = 1'b1;
          far_d   = 1'b1;
          state_d = DS_IDLE;
        end else begin
          mul_a   = MUL_A_W'(num[NUM_W-1:IDX_PRE_SHIFT]);
          mul_b   = IDX_RECIP;
          state_d = DS_IDX;
        end
      end
      DS_IDX: begin
        if (prod_q[PROD_W-1:IDX_RECIP_SHIFT+IDX_W] != '0) begin
          idx_d = IDX_MAX;
        end else begin
          idx_d = prod_q[IDX_RECIP_SHIFT+IDX_W-1:IDX_RECIP_SHIFT];
        end
        state_d = DS_MUL_PX;
      end
      DS_MUL_PX: begin
        mul_a   = MUL_A_W'(ao_q);
        mul_b   = MUL_B_W'(COS_LUT[idx_q]);
        state_d = DS_CHK_PX;
      end
      DS_CHK_PX: begin
        if (prod_q[PROD_W-1:PX_BITS] != '0) begin
          done_d  = 1'b1;
          far_d   = 1'b1;
          state_d = DS_IDLE;
        end else begin
          xs_d    = px_rnd[PX_BITS:8];
          state_d = DS_MUL_XX;
        end
      end
      DS_MUL_XX: begin
        mul_a   = MUL_A_W'(xs_q);
        mul_b   = xs_q;
        state_d = DS_MUL_YY;
      end
      DS_MUL_YY: begin
        mul_a   = MUL_A_W'(ys);
        mul_b   = MUL_B_W'(ys);
        acc_d   = prod_q;
        state_d = DS_MUL_TT;
      end
      DS_MUL_TT: begin
        mul_a   = MUL_A_W'(thr_i);
        mul_b   = MUL_B_W'(thr_i);
        acc_d   = acc_q + prod_q;
        state_d = DS_MUL_TS;
      end
      DS_MUL_TS: begin
        mul_a   = prod_q[MUL_A_W-1:0];
        mul_b   = DIST_SCALE;
        state_d = DS_CMP;
      end
      DS_CMP: begin
        done_d  = 1'b1;
        far_d   = (acc_q >= prod_q);
        state_d = DS_IDLE;
      end
      default: begin
        state_d = DS_IDLE;
      end
    endcase

    prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
      done_q  <= 1'b0;
      far_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      far_q   <= far_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dlat_q <= dlat_d;
    dlon_q <= dlon_d;
    msum_q <= msum_d;
    ad_q   <= ad_d;
    ao_q   <= ao_d;
    ms_q   <= ms_d;
    idx_q  <= idx_d;
    xs_q   <= xs_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.far  = far_q;

endmodule

/* design/position_commit_filter.sv */
// Channel    Direction  Handshake               Contents
// s_axis     in         s_axis_tvalid/tready    one position fix
// m_axis     out        m_axis_tvalid/tready    commit decision, committed position and poll period
// apb        in/out     psel/penable/pready     profile, interval and distance registers
//
// A fix that needs no distance check passes from ST_EVAL to ST_DONE, where its result is
// loaded into the output register; no new fix is taken until the state returns to ST_IDLE.
// A fix that needs the distance check waits in ST_DIST until pcf_dist reports done; pcf_dist
// issues its products on the one shared multiplier in DS_DECIDE and the DS_MUL_* states.
// Reset clears the committed position and time, have_q, out_valid_q and the config registers.
// A stalled result waits in the output register; the next fix is accepted meanwhile.
module position_commit_filter
  import pcf_pkg::*;
#(
  parameter int HEARTBEAT_SECONDS = HEARTBEAT_SECONDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // latitude [27:0], longitude [56:28], time_ms [88:57], zero [95:89]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // fix_ok [0]
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // commit_latitude [27:0], commit_longitude [56:28], poll_period [61:57], zero [63:62]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // committed [0]
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [TIME_W-1:0] HB_MS = TIME_W'(HEARTBEAT_SECONDS * MS_PER_SECOND);
  localparam logic [POLL_W-1:0] POLL_CAP =
    POLL_W'((HEARTBEAT_SECONDS > POLL_FIELD_MAX) ? POLL_FIELD_MAX : HEARTBEAT_SECONDS);

  pcf_state_e               state_q, state_d;
  logic [PROF_W-1:0]        profile_q, profile_d;
  logic [CFG_W-1:0]         interval_q, interval_d;
  logic [CFG_W-1:0]         distance_q, distance_d;
  logic                     fix_q, fix_d;
  logic signed [LAT_W-1:0]  lat_q, lat_d;
  logic signed [LON_W-1:0]  lon_q, lon_d;
  logic [TIME_W-1:0]        time_q, time_d;
  logic signed [LAT_W-1:0]  last_lat_q, last_lat_d;
  logic signed [LON_W-1:0]  last_lon_q, last_lon_d;
  logic [TIME_W-1:0]        last_time_q, last_time_d;
  logic                     have_q, have_d;
  logic                     commit_q, commit_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_commit_q, out_commit_d;
  logic signed [LAT_W-1:0]  out_lat_q, out_lat_d;
  logic signed [LON_W-1:0]  out_lon_q, out_lon_d;
  logic [POLL_W-1:0]        out_poll_q, out_poll_d;

  logic [CFG_W-1:0]         thr;
  logic [CFG_W-1:0]         interval;
  logic [POLL_W-1:0]        poll;
  logic [TIME_W-1:0]        elapsed;
  logic                     cfg_wr;
  logic                     dist_start;
  dist_stat_t               dist_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  assign thr      = (distance_q != '0) ? distance_q : DISTANCE_BY_PROFILE[profile_q];
  assign interval = (interval_q != '0) ? interval_q : INTERVAL_BY_PROFILE[profile_q];
  assign poll     = (interval > CFG_W'(POLL_CAP)) ? POLL_CAP : interval[POLL_W-1:0];
  assign elapsed  = time_q - last_time_q;

  always_comb begin
    case (paddr[3:2])
      REG_PROFILE:  prdata = APB_DATA_W'(profile_q);
      REG_INTERVAL: prdata = APB_DATA_W'(interval_q);
      REG_DISTANCE: prdata = APB_DATA_W'(distance_q);
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    profile_d  = profile_q;
    interval_d = interval_q;
    distance_d = distance_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_PROFILE:  profile_d  = pwdata[PROF_W-1:0];
        REG_INTERVAL: interval_d = pwdata[CFG_W-1:0];
        REG_DISTANCE: distance_d = pwdata[CFG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    fix_d        = fix_q;
    lat_d        = lat_q;
    lon_d        = lon_q;
    time_d       = time_q;
    last_lat_d   = last_lat_q;
    last_lon_d   = last_lon_q;
    last_time_d  = last_time_q;
    have_d       = have_q;
    commit_d     = commit_q;
    out_commit_d = out_commit_q;
    out_lat_d    = out_lat_q;
    out_lon_d    = out_lon_q;
    out_poll_d   = out_poll_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    dist_start   = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          fix_d   = s_axis_tuser;
          lat_d   = s_axis_tdata[LAT_W-1:0];
          lon_d   = s_axis_tdata[LAT_W+LON_W-1:LAT_W];
          time_d  = s_axis_tdata[LAT_W+LON_W+TIME_W-1:LAT_W+LON_W];
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!fix_q) begin
          commit_d = 1'b0;
          state_d  = ST_DONE;
        end else if (!have_q || thr == '0 || elapsed >= HB_MS) begin
          commit_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          dist_start = 1'b1;
          state_d    = ST_DIST;
        end
      end
      ST_DIST: begin
        if (dist_stat.done) begin
          commit_d = dist_stat.far;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          if (commit_q) begin
            last_lat_d  = lat_q;
            last_lon_d  = lon_q;
            last_time_d = time_q;
            have_d      = 1'b1;
            out_lat_d   = lat_q;
            out_lon_d   = lon_q;
          end else begin
            out_lat_d = last_lat_q;
            out_lon_d = last_lon_q;
          end
          out_commit_d = commit_q;
          out_poll_d   = poll;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      profile_q   <= '0;
      interval_q  <= '0;
      distance_q  <= '0;
      last_lat_q  <= '0;
      last_lon_q  <= '0;
      last_time_q <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      profile_q   <= profile_d;
      interval_q  <= interval_d;
      distance_q  <= distance_d;
      last_lat_q  <= last_lat_d;
      last_lon_q  <= last_lon_d;
      last_time_q <= last_time_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fix_q        <= fix_d;
    lat_q        <= lat_d;
    lon_q        <= lon_d;
    time_q       <= time_d;
    commit_q     <= commit_d;
    out_commit_q <= out_commit_d;
    out_lat_q    <= out_lat_d;
    out_lon_q    <= out_lon_d;
    out_poll_q   <= out_poll_d;
  end

  pcf_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dist_start),
    .lat_i      (lat_q),
    .lon_i      (lon_q),
    .last_lat_i (last_lat_q),
    .last_lon_i (last_lon_q),
    .thr_i      (thr),
    .stat_o     (dist_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_commit_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_poll_q, out_lon_q, out_lat_q});

  a_dist_only_in_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_stat.done |-> state_q == ST_DIST)
    else $error("distance result outside of distance wait");

  a_out_matches_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_lat_q == last_lat_q && out_lon_q == last_lon_q))
    else $error("shown position differs from committed position");

  a_commit_sets_have: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_commit_q) |-> have_q)
    else $error("commit reported without a committed position");

  a_poll_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_poll_q <= POLL_CAP)
    else $error("poll period above cap");

  a_start_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_start |=> state_q == ST_DIST)
    else $error("distance check started without waiting for it");

endmodule

/* bench/tb_position_commit_filter.sv */
`timescale 1ns / 1ps

module tb_position_commit_filter;
  import pcf_pkg::*;

  typedef longint unsigned u64_t;

  typedef enum logic [1:0] {
    WALKING,
    CYCLING,
    DRIVING,
    MANUAL
  } profile_e;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 25;
  localparam int SEGMENTS       = 12;
  localparam int TRACKS_PER_SEG = 4;
  localparam int FIXES_PER_TRACK = 22;

  localparam int SRC_IDLE   [4] = '{0, 66, 0, 20};
  localparam int SINK_STALL [4] = '{0, 0, 66, 20};

  localparam logic [1:0]  SEG_PROFILE  [SEGMENTS] =
    '{WALKING, CYCLING, DRIVING, MANUAL, WALKING, MANUAL,
      CYCLING, DRIVING, WALKING, WALKING, MANUAL, WALKING};
  localparam logic [15:0] SEG_INTERVAL [SEGMENTS] =
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd1,
      16'd30, 16'd31, 16'd29, 16'd0, 16'd0, 16'd0};
  localparam logic [15:0] SEG_DISTANCE [SEGMENTS] =
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 16'd1,
      16'd0, 16'd1000, 16'd65535, 16'd0, 16'd7, 16'd0};

  typedef struct packed {
    logic              fix_ok;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic [TIME_W-1:0] time_ms;
  } fix_t;

  typedef struct packed {
    logic              committed;
    logic [LAT_W-1:0]  lat;
    logic [LON_W-1:0]  lon;
    logic [POLL_W-1:0] poll;
  } commit_report_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fix_t           fix_queue [$];
  commit_report_t commit_reports [$];

  logic [1:0]  cfg_profile  = WALKING;
  logic [15:0] cfg_interval = '0;
  logic [15:0] cfg_distance = '0;

  longint      anchor_lat   = 0;
  longint      anchor_lon   = 0;
  logic [31:0] anchor_time  = '0;
  bit          anchor_valid = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit fix_taken      = 1'b0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int fixes_judged   = 0;
  int commits_seen   = 0;
  int settings_used  = 0;

  position_commit_filter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic note_mismatch(string what, u64_t want, u64_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  function automatic u64_t magnitude(longint v);
    return (v < 0) ? u64_t'(-v) : u64_t'(v);
  endfunction

  // Cosine of table step idx (0..90 degrees over the table) in Q1.16,
  // from a truncating Q2.30 Taylor series.
  function automatic u64_t cos_q16(u64_t idx);
    u64_t   ang;
    u64_t   ang2;
    u64_t   term;
    longint acc;
    ang  = (PIHALF_Q30 * idx) / u64_t'(COS_DEPTH - 1);
    ang2 = (ang * ang + (u64_t'(1) << 29)) >> 30;
    term = Q30_ONE;
    acc  = longint'(Q30_ONE);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * ang2) >> 30) / u64_t'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(Q30_ONE)) begin
      acc = longint'(Q30_ONE);
    end
    return (u64_t'(acc) + 8192) >> 14;
  endfunction

  function automatic bit beyond_deadband(longint lat, longint lon, u64_t thr);
    u64_t dlat_m;
    u64_t dlon_m;
    u64_t lat_sum;
    u64_t idx;
    u64_t px;
    u64_t xs;
    u64_t ys;
    dlat_m  = magnitude(lat - anchor_lat);
    dlon_m  = magnitude(lon - anchor_lon);
    lat_sum = magnitude(lat + anchor_lat);
    if (dlat_m >= (u64_t'(1) << NEAR_BITS)) begin
      return 1'b1;
    end
    idx = (lat_sum * u64_t'(COS_DEPTH - 1) + MDEG_90) / MDEG_180;
    if (idx > u64_t'(COS_DEPTH - 1)) begin
      idx = u64_t'(COS_DEPTH - 1);
    end
    px = dlon_m * cos_q16(idx);
    if (px >= (u64_t'(1) << PX_BITS)) begin
      return 1'b1;
    end
    xs = (px + 128) >> 8;
    ys = dlat_m << 8;
    return xs * xs + ys * ys >= thr * thr * u64_t'(DIST_SCALE);
  endfunction

  function automatic u64_t commit_distance();
    return (cfg_distance != 0) ? u64_t'(cfg_distance) : u64_t'(DISTANCE_BY_PROFILE[cfg_profile]);
  endfunction

  function automatic commit_report_t judge_fix(fix_t f);
    longint         lat;
    longint         lon;
    u64_t           thr;
    u64_t           poll;
    u64_t           cap;
    logic [31:0]    elapsed;
    bit             take;
    commit_report_t r;
    lat     = longint'($signed(f.lat));
    lon     = longint'($signed(f.lon));
    thr     = commit_distance();
    poll    = (cfg_interval != 0) ? u64_t'(cfg_interval)
                                  : u64_t'(INTERVAL_BY_PROFILE[cfg_profile]);
    elapsed = f.time_ms - anchor_time;
    take    = 1'b0;
    if (f.fix_ok) begin
      if (!anchor_valid || thr == 0) begin
        take = 1'b1;
      end else if (elapsed >= 32'(HEARTBEAT_SECONDS_DEF * MS_PER_SECOND)) begin
        take = 1'b1;
      end else begin
        take = beyond_deadband(lat, lon, thr);
      end
    end
    if (take) begin
      anchor_lat   = lat;
      anchor_lon   = lon;
      anchor_time  = f.time_ms;
      anchor_valid = 1'b1;
    end
    cap = u64_t'((HEARTBEAT_SECONDS_DEF > POLL_FIELD_MAX) ? POLL_FIELD_MAX
                                                           : HEARTBEAT_SECONDS_DEF);
    if (poll > cap) begin
      poll = cap;
    end
    r.committed = take;
    r.lat       = anchor_lat[LAT_W-1:0];
    r.lon       = anchor_lon[LON_W-1:0];
    r.poll      = poll[POLL_W-1:0];
    return r;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(negedge clk_i) begin : fix_driver
    fix_t f;
    if (rst_ni && !(s_axis_tvalid && !fix_taken)) begin
      if (fix_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        f = fix_queue.pop_front();
        s_axis_tdata  <= IN_DATA_W'({f.time_ms, f.lon, f.lat});
        s_axis_tuser  <= f.fix_ok;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : report_monitor
    fix_t           f;
    commit_report_t want;
    bit             moved;
    fix_taken = 1'b0;
    if (rst_ni) begin
      moved = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (m_axis_tuser) begin
          commits_seen++;
        end
        if (commit_reports.size() == 0) begin
          note_mismatch("report with nothing expected", 0, m_axis_tdata);
        end else begin
          want = commit_reports.pop_front();
          if (m_axis_tuser !== want.committed) begin
            note_mismatch("committed", want.committed, m_axis_tuser);
          end
          if (m_axis_tdata[LAT_W-1:0] !== want.lat) begin
            note_mismatch("commit_latitude", want.lat, m_axis_tdata[LAT_W-1:0]);
          end
          if (m_axis_tdata[LAT_W+LON_W-1:LAT_W] !== want.lon) begin
            note_mismatch("commit_longitude", want.lon, m_axis_tdata[LAT_W+LON_W-1:LAT_W]);
          end
          if (m_axis_tdata[LAT_W+LON_W+POLL_W-1:LAT_W+LON_W] !== want.poll) begin
            note_mismatch("poll_period", want.poll,
                          m_axis_tdata[LAT_W+LON_W+POLL_W-1:LAT_W+LON_W]);
          end
          if (m_axis_tdata[OUT_DATA_W-1:LAT_W+LON_W+POLL_W] !== '0) begin
            note_mismatch("tdata padding", 0, m_axis_tdata[OUT_DATA_W-1:LAT_W+LON_W+POLL_W]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved     = 1'b1;
        fix_taken = 1'b1;
        f.fix_ok  = s_axis_tuser;
        f.lat     = s_axis_tdata[LAT_W-1:0];
        f.lon     = s_axis_tdata[LAT_W+LON_W-1:LAT_W];
        f.time_ms = s_axis_tdata[LAT_W+LON_W+TIME_W-1:LAT_W+LON_W];
        commit_reports.push_back(judge_fix(f));
        fixes_judged++;
      end
      if (psel && penable && pready) begin
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic push_fix(bit ok, longint lat, longint lon, logic [31:0] stamp);
    fix_t f;
    f.fix_ok  = ok;
    f.lat     = lat[LAT_W-1:0];
    f.lon     = lon[LON_W-1:0];
    f.time_ms = stamp;
    fix_queue.push_back(f);
  endtask

  task automatic wait_quiet();
    do begin
      @(posedge clk_i);
    end while (fix_queue.size() != 0 || s_axis_tvalid || commit_reports.size() != 0);
  endtask

  task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_and_verify(logic [1:0] idx, logic [31:0] value, logic [31:0] mask);
    logic [31:0] noise;
    logic [31:0] rd;
    noise = $urandom;
    apb_access(1'b1, idx, (noise & ~mask) | (value & mask), rd);
    apb_access(1'b0, idx, '0, rd);
    if (rd !== (value & mask)) begin
      note_mismatch("register read-back", value & mask, rd);
    end
  endtask

  // Registers change only once every fix in flight has reported.
  task automatic set_config(logic [1:0] prof, logic [15:0] intv, logic [15:0] dist_m);
    logic [31:0] rd;
    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_and_verify(REG_PROFILE, 32'(prof), 32'h3);
    cfg_profile = prof;
    write_and_verify(REG_INTERVAL, 32'(intv), 32'hFFFF);
    cfg_interval = intv;
    write_and_verify(REG_DISTANCE, 32'(dist_m), 32'hFFFF);
    cfg_distance = dist_m;
    if (settings_used == 0) begin
      apb_access(1'b1, REG_UNUSED, $urandom, rd);
    end
    settings_used++;
  endtask

  // A track is a run of fixes around one moving point, sized to the
  // commit distance so that near and far steps both occur.
  task automatic queue_track(int count, u64_t thr);
    int unsigned pick;
    int unsigned step;
    longint      lat;
    longint      lon;
    logic [31:0] clock_ms;
    lat      = longint'($urandom_range(170000000)) - 85000000;
    lon      = longint'($urandom_range(360000000)) - 180000000;
    clock_ms = $urandom;
    step     = (thr == 0) ? 500 : int'(thr) * 18 + 2;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        lat = lat + longint'($urandom_range(2 * step)) - longint'(step);
        lon = lon + longint'($urandom_range(2 * step)) - longint'(step);
        if (lat > 90000000) lat = 90000000;
        if (lat < -90000000) lat = -90000000;
        if (lon > 180000000) lon = 180000000;
        if (lon < -180000000) lon = -180000000;
        clock_ms += $urandom_range(12000);
        push_fix(1'b1, lat, lon, clock_ms);
      end else if (pick < 75) begin
        clock_ms += $urandom_range(2000);
        push_fix(1'b1, lat, lon, clock_ms);
      end else if (pick < 80) begin
        clock_ms += $urandom_range(30002, 29998);
        push_fix(1'b1, lat, lon, clock_ms);
      end else if (pick < 90) begin
        push_fix(1'b0, longint'($urandom), longint'($urandom), $urandom);
      end else begin
        push_fix(1'b1, longint'($urandom), longint'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    logic [1:0]  prof;
    logic [15:0] intv;
    logic [15:0] dist_m;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(WALKING, 16'd0, 16'd0);
    push_fix(1'b0, 12345678, -7654321, 100);
    push_fix(1'b1, 0, 0, 0);
    push_fix(1'b1, 44, 0, 1000);
    push_fix(1'b1, 45, 0, 2000);
    push_fix(1'b1, 45, 45, 3000);
    push_fix(1'b1, 45, 45, 32999);
    push_fix(1'b1, 45, 45, 33000);
    push_fix(1'b0, -90000000, -180000000, 40000);
    push_fix(1'b1, 90000000, 180000000, 40000);
    push_fix(1'b1, 89999990, -180000000, 41000);
    push_fix(1'b1, -90000000, -180000000, 42000);
    push_fix(1'b1, -(1 << 27), -(1 << 28), 43000);
    push_fix(1'b1, (1 << 27) - 1, (1 << 28) - 1, 44000);
    push_fix(1'b1, (1 << 27) - 5, (1 << 28) - 1, 45000);
    push_fix(1'b1, 0, 0, 32'hFFFF_FC18);
    push_fix(1'b1, 0, 0, 28999);
    push_fix(1'b1, 0, 0, 29000);
    push_fix(1'b1, 0, 1 << 20, 30000);
    push_fix(1'b0, -1, -1, 32'hFFFF_FFFF);
    set_config(MANUAL, 16'd0, 16'd0);
    push_fix(1'b1, 0, 1 << 20, 31000);
    push_fix(1'b0, 5, 5, 32000);
    set_config(WALKING, 16'd65535, 16'd65535);
    push_fix(1'b1, 3000000, 0, 33000);
    push_fix(1'b1, 3500000, 0, 34000);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      prof   = SEG_PROFILE[seg];
      intv   = SEG_INTERVAL[seg];
      dist_m = SEG_DISTANCE[seg];
      if (seg == 9 || seg == 11) begin
        prof   = $urandom_range(3);
        intv   = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535));
        dist_m = ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(200));
      end
      set_config(prof, intv, dist_m);
      src_idle_pct   = SRC_IDLE[seg % 4];
      sink_stall_pct = SINK_STALL[seg % 4];
      repeat (TRACKS_PER_SEG) queue_track(FIXES_PER_TRACK, commit_distance());
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("tb: %0d fixes judged, %0d committed, over %0d register settings",
             fixes_judged, commits_seen, settings_used);
    $display("tb: idle mixes none/sender/receiver/both exercised, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pcf_pkg.sv
design/pcf_dist.sv
design/position_commit_filter.sv
bench/tb_position_commit_filter.sv
